### hdl/fce_pkg.sv
package fce_pkg;

    localparam int MAX_HARMONICS_DEF    = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int COEF_WIDTH_DEF       = 32;

    localparam int WGT_W   = 48;
    localparam int ACC_W   = 64;
    localparam int OUT_W   = 48;
    localparam int SINE_W  = 16;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TWO_PI_Q16  = 64'd411775;
    localparam longint unsigned TERM_LIMIT  = 64'h0100_0000_0000_0000;

    localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sh0000_8000_0000_0000;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic REG_HARMONIC_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic coef_we;
        logic start;
        logic issue;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_valid;
    } status_t;

endpackage

### hdl/fce_ctrl.sv
module fce_ctrl #(
    parameter int MAX_HARMONICS = fce_pkg::MAX_HARMONICS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic                out_stall,
    input  logic [4:0]          harmonic_count,
    input  fce_pkg::status_t    status,
    output fce_pkg::cmd_t       cmd,
    output logic [(MAX_HARMONICS > 1 ? $clog2(MAX_HARMONICS) : 1)-1:0] jslot
);

    localparam int HIDX = MAX_HARMONICS > 1 ? $clog2(MAX_HARMONICS) : 1;
    localparam int JW   = $clog2(MAX_HARMONICS + 1);

    fce_pkg::state_t state_reg, state_next;
    logic [JW-1:0]   jcnt_reg, jcnt_next;
    logic [JW-1:0]   n_eff;
    logic [JW-1:0]   jm1;
    logic            out_free;

    always_comb
    begin
        if (int'(harmonic_count) > MAX_HARMONICS)
        begin
            n_eff = JW'(MAX_HARMONICS);
        end
        else
        begin
            n_eff = JW'(harmonic_count);
        end
    end

    assign out_free = !status.out_valid || !out_stall;
    assign jm1      = jcnt_reg - 1'b1;
    assign jslot    = HIDX'(jm1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fce_pkg::ST_IDLE;
            jcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            jcnt_reg  <= jcnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        jcnt_next  = jcnt_reg;
        unique case (state_reg)
            fce_pkg::ST_IDLE:
            begin
                if (in_valid && mode == fce_pkg::MODE_EVAL)
                begin
                    state_next = fce_pkg::ST_RUN;
                    jcnt_next  = JW'(1);
                end
            end
            fce_pkg::ST_RUN:
            begin
                jcnt_next = jcnt_reg + 1'b1;
                if (n_eff == '0 || jcnt_reg == n_eff)
                begin
                    state_next = fce_pkg::ST_DRAIN;
                end
            end
            fce_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = fce_pkg::ST_DONE;
                end
            end
            fce_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fce_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            fce_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.coef_we  = in_valid && mode == fce_pkg::MODE_LOAD;
                cmd.start    = in_valid && mode == fce_pkg::MODE_EVAL;
            end
            fce_pkg::ST_RUN:
            begin
                cmd.issue = n_eff != '0;
            end
            fce_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            fce_pkg::ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hdl/fce_dpath.sv
module fce_dpath #(
    parameter int MAX_HARMONICS    = fce_pkg::MAX_HARMONICS_DEF,
    parameter int SINE_TABLE_DEPTH = fce_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int COEF_WIDTH       = fce_pkg::COEF_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fce_pkg::cmd_t           cmd,
    input  logic [(MAX_HARMONICS > 1 ? $clog2(MAX_HARMONICS) : 1)-1:0] jslot,
    output fce_pkg::status_t        status,
    input  logic [1:0]              coef_axis,
    input  logic [5:0]              coef_index,
    input  logic signed [31:0]      coef_value,
    input  logic [15:0]             phase,
    input  logic [1:0]              deriv_order,
    input  logic                    last_point,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic signed [47:0]      x_out,
    output logic signed [47:0]      y_out,
    output logic signed [47:0]      z_out,
    output logic                    saturated,
    output logic                    last_out
);

    localparam int HIDX = MAX_HARMONICS > 1 ? $clog2(MAX_HARMONICS) : 1;
    localparam int CW   = COEF_WIDTH < 32 ? COEF_WIDTH : 32;
    localparam int RW   = SINE_TABLE_DEPTH > 1 ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam int PW   = CW + 17;
    localparam int AW   = CW + 3;
    localparam int PRW  = AW + 49;
    localparam int WH   = fce_pkg::WGT_W / 2;
    localparam int TW   = 58;
    localparam int NW   = MAX_HARMONICS * 4;

    typedef logic signed [fce_pkg::SINE_W-1:0] rom_t [SINE_TABLE_DEPTH];
    typedef logic [fce_pkg::WGT_W-1:0] wtab_t [NW];

    function automatic longint signed rom_sine(longint unsigned idx);
        longint unsigned f, quad, r, x, x2, t, s, q;
        f    = (idx << 32) / SINE_TABLE_DEPTH;
        quad = (f >> 30) & 64'd3;
        r    = f & (fce_pkg::Q30_ONE - 64'd1);
        if (quad[0])
        begin
            r = fce_pkg::Q30_ONE - r;
        end
        x  = (r * fce_pkg::HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = fce_pkg::Q30_ONE - x2 / 72;
        t  = fce_pkg::Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = fce_pkg::Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = fce_pkg::Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return quad[1] ? -longint'(q) : longint'(q);
    endfunction

    function automatic rom_t build_rom();
        rom_t rom;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            rom[i] = fce_pkg::SINE_W'(rom_sine(longint'(i)));
        end
        return rom;
    endfunction

    function automatic wtab_t build_wtab();
        wtab_t tab;
        longint unsigned w1, w2, w3;
        for (int j = 1; j <= MAX_HARMONICS; j++)
        begin
            w1 = longint'(j) * fce_pkg::TWO_PI_Q16;
            w2 = (w1 * w1 + 64'd32768) >> 16;
            w3 = (w2 * w1 + 64'd32768) >> 16;
            tab[(j-1)*4 + 0] = fce_pkg::WGT_W'(64'd65536);
            tab[(j-1)*4 + 1] = fce_pkg::WGT_W'(w1);
            tab[(j-1)*4 + 2] = fce_pkg::WGT_W'(w2);
            tab[(j-1)*4 + 3] = fce_pkg::WGT_W'(w3);
        end
        return tab;
    endfunction

    localparam rom_t  SINE_ROM = build_rom();
    localparam wtab_t WGT_TAB  = build_wtab();

    // coefficient store
    logic signed [CW-1:0] sin_mem [3][MAX_HARMONICS];
    logic signed [CW-1:0] cos_mem [3][MAX_HARMONICS];
    logic [MAX_HARMONICS-1:0] sin_vld_reg [3];
    logic [MAX_HARMONICS-1:0] cos_vld_reg [3];
    logic signed [CW-1:0] const_reg [3];

    logic [6:0]      kk;
    logic [6:0]      slot7;
    logic [HIDX-1:0] wslot;
    logic            in_range;
    logic            axis_ok;

    logic [15:0] phase_reg, angle_reg;
    logic [1:0]  deriv_reg;
    logic        last_reg;

    // stage a
    logic                          va_reg;
    logic signed [CW-1:0]          srd_reg [3];
    logic signed [CW-1:0]          crd_reg [3];
    logic [2:0]                    srv_reg, crv_reg;
    logic signed [fce_pkg::SINE_W-1:0] sinv_reg, cosv_reg;
    logic [fce_pkg::WGT_W-1:0]     wa_reg;
    logic [15:0]                   cangle;
    logic [31:0]                   sprod, cprod;
    logic [RW-1:0]                 sidx, cidx;

    // stage b
    logic                          vb_reg;
    logic signed [PW-1:0]          pb_reg [3];
    logic [fce_pkg::WGT_W-1:0]     wb_reg;
    logic signed [CW+15:0]         ms [3];
    logic signed [CW+15:0]         mc [3];
    logic signed [CW-1:0]          sval [3];
    logic signed [CW-1:0]          cval [3];

    // stage c
    logic                          vc_reg;
    logic [AW-1:0]                 mag_reg [3];
    logic [2:0]                    negc_reg;
    logic [fce_pkg::WGT_W-1:0]     wc_reg;
    logic signed [PW:0]            tc [3];
    logic signed [AW-1:0]          p16 [3];

    // stage d
    logic                          vd_reg;
    logic [AW+WH-1:0]              pp0_reg [3];
    logic [AW+WH-1:0]              pp1_reg [3];
    logic [2:0]                    negd_reg;

    // stage e
    logic                          ve_reg;
    logic signed [TW-1:0]          term_reg [3];
    logic [2:0]                    tclip_reg;
    logic [PRW-1:0]                prod [3];
    logic [PRW-1:0]                rr [3];
    logic [TW-2:0]                 mg [3];
    logic [2:0]                    clip;

    // accumulate and output
    logic signed [fce_pkg::ACC_W-1:0] acc_reg [3];
    logic                          sat_reg;
    logic signed [fce_pkg::OUT_W-1:0] res [3];
    logic [2:0]                    oclip;
    logic                          out_valid_reg;
    logic signed [47:0]            x_reg, y_reg, z_reg;
    logic                          sat_out_reg, last_out_reg;

    // load decode
    assign kk       = {1'b0, coef_index};
    assign in_range = {2'b00, coef_index} <= 8'(2 * MAX_HARMONICS);
    assign axis_ok  = coef_axis != 2'd3;
    assign slot7    = coef_index[0] ? (kk >> 1) : ((kk >> 1) - 7'd1);
    assign wslot    = HIDX'(slot7);

    always_ff @(posedge clk)
    begin
        if (cmd.coef_we && axis_ok && in_range && coef_index != 6'd0)
        begin
            if (coef_index[0])
            begin
                sin_mem[coef_axis][wslot] <= coef_value[CW-1:0];
            end
            else
            begin
                cos_mem[coef_axis][wslot] <= coef_value[CW-1:0];
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            srd_reg[a] <= sin_mem[a][jslot];
            crd_reg[a] <= cos_mem[a][jslot];
        end
        sinv_reg <= SINE_ROM[sidx];
        cosv_reg <= SINE_ROM[cidx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sin_vld_reg[a] <= '0;
                cos_vld_reg[a] <= '0;
                const_reg[a]   <= '0;
            end
        end
        else if (cmd.coef_we && axis_ok && in_range)
        begin
            if (coef_index == 6'd0)
            begin
                const_reg[coef_axis] <= coef_value[CW-1:0];
            end
            else if (coef_index[0])
            begin
                sin_vld_reg[coef_axis][wslot] <= 1'b1;
            end
            else
            begin
                cos_vld_reg[coef_axis][wslot] <= 1'b1;
            end
        end
    end

    // angle and table lookup
    assign cangle = angle_reg + 16'd16384;
    assign sprod  = 32'(angle_reg) * 32'(SINE_TABLE_DEPTH);
    assign cprod  = 32'(cangle) * 32'(SINE_TABLE_DEPTH);
    assign sidx   = sprod[16 +: RW];
    assign cidx   = cprod[16 +: RW];

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            phase_reg <= phase;
            angle_reg <= phase + {deriv_order, 14'd0};
            deriv_reg <= deriv_order;
            last_reg  <= last_point;
        end
        else if (cmd.issue)
        begin
            angle_reg <= angle_reg + phase_reg;
        end
        wa_reg <= WGT_TAB[{jslot, deriv_reg}];
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sval[a] = srv_reg[a] ? srd_reg[a] : '0;
            cval[a] = crv_reg[a] ? crd_reg[a] : '0;
            ms[a]   = sval[a] * sinv_reg;
            mc[a]   = cval[a] * cosv_reg;
            tc[a]   = {pb_reg[a][PW-1], pb_reg[a]} + (PW+1)'(16384);
            p16[a]  = tc[a][PW:15];
            prod[a] = PRW'(pp0_reg[a]) + (PRW'(pp1_reg[a]) << WH);
            rr[a]   = (prod[a] + PRW'(32768)) >> 16;
            clip[a] = rr[a] > PRW'(fce_pkg::TERM_LIMIT);
            mg[a]   = clip[a] ? (TW-1)'(fce_pkg::TERM_LIMIT) : rr[a][TW-2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            pb_reg[a]   <= {ms[a][CW+15], ms[a]} + {mc[a][CW+15], mc[a]};
            mag_reg[a]  <= p16[a][AW-1] ? AW'(-p16[a]) : AW'(p16[a]);
            pp0_reg[a]  <= mag_reg[a] * wc_reg[WH-1:0];
            pp1_reg[a]  <= mag_reg[a] * wc_reg[fce_pkg::WGT_W-1:WH];
            term_reg[a] <= negd_reg[a] ? -$signed({1'b0, mg[a]}) : $signed({1'b0, mg[a]});
            negc_reg[a] <= p16[a][AW-1];
        end
        wb_reg    <= wa_reg;
        wc_reg    <= wb_reg;
        negd_reg  <= negc_reg;
        tclip_reg <= clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            vd_reg  <= 1'b0;
            ve_reg  <= 1'b0;
            srv_reg <= '0;
            crv_reg <= '0;
        end
        else
        begin
            va_reg <= cmd.issue;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            for (int a = 0; a < 3; a++)
            begin
                srv_reg[a] <= sin_vld_reg[a][jslot];
                crv_reg[a] <= cos_vld_reg[a][jslot];
            end
        end
    end

    // accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= (deriv_order == 2'd0) ? fce_pkg::ACC_W'(const_reg[a]) : '0;
            end
            sat_reg <= 1'b0;
        end
        else if (ve_reg)
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= acc_reg[a] + fce_pkg::ACC_W'(term_reg[a]);
            end
            sat_reg <= sat_reg | (|tclip_reg);
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (acc_reg[a] > fce_pkg::OUT_MAX)
            begin
                res[a]   = fce_pkg::OUT_W'(fce_pkg::OUT_MAX);
                oclip[a] = 1'b1;
            end
            else if (acc_reg[a] < fce_pkg::OUT_MIN)
            begin
                res[a]   = fce_pkg::OUT_W'(fce_pkg::OUT_MIN);
                oclip[a] = 1'b1;
            end
            else
            begin
                res[a]   = acc_reg[a][fce_pkg::OUT_W-1:0];
                oclip[a] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            x_reg        <= res[0];
            y_reg        <= res[1];
            z_reg        <= res[2];
            sat_out_reg  <= sat_reg | (|oclip);
            last_out_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.pipe_busy = va_reg | vb_reg | vc_reg | vd_reg | ve_reg;
    assign status.out_valid = out_valid_reg;
    assign out_valid        = out_valid_reg;
    assign x_out            = x_reg;
    assign y_out            = y_reg;
    assign z_out            = z_reg;
    assign saturated        = sat_out_reg;
    assign last_out         = last_out_reg;

endmodule

### hdl/fourier_curve_evaluator_unit.sv
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   mode, coef_axis, coef_index, coef_value,
//                                            phase, deriv_order, last_point
// output    out        out_valid / out_stall x_out, y_out, z_out, saturated, last_out
// config    in         apb psel/penable      harmonic_count at byte 0
//
// after a load transfer the block is ready again the next cycle
// an evaluate result is loaded once its n harmonics (n the harmonic count in use) have drained
// from the pipeline and the output is free; the next transfer is taken the cycle after the load
// one harmonic enters the five-stage term pipeline per cycle, all three axes at once
// the input stalls while an evaluation runs; a held result does not block loads
// reset clears the control state and every coefficient reads zero until written
module fourier_curve_evaluator_unit #(
    parameter int MAX_HARMONICS    = fce_pkg::MAX_HARMONICS_DEF,
    parameter int SINE_TABLE_DEPTH = fce_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int COEF_WIDTH       = fce_pkg::COEF_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [1:0]         coef_axis,
    input  logic [5:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic [15:0]        phase,
    input  logic [1:0]         deriv_order,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] x_out,
    output logic signed [47:0] y_out,
    output logic signed [47:0] z_out,
    output logic               saturated,
    output logic               last_out
);

    localparam int HIDX = MAX_HARMONICS > 1 ? $clog2(MAX_HARMONICS) : 1;

    logic [4:0]       hc_reg;
    fce_pkg::cmd_t    cmd;
    fce_pkg::status_t status;
    logic [HIDX-1:0]  jslot;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == fce_pkg::REG_HARMONIC_COUNT)
        begin
            hc_reg <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == fce_pkg::REG_HARMONIC_COUNT) ? 32'(hc_reg) : '0;

    fce_ctrl #(
        .MAX_HARMONICS (MAX_HARMONICS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .out_stall      (out_stall),
        .harmonic_count (hc_reg),
        .status         (status),
        .cmd            (cmd),
        .jslot          (jslot)
    );

    fce_dpath #(
        .MAX_HARMONICS    (MAX_HARMONICS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .COEF_WIDTH       (COEF_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .jslot       (jslot),
        .status      (status),
        .coef_axis   (coef_axis),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .phase       (phase),
        .deriv_order (deriv_order),
        .last_point  (last_point),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .x_out       (x_out),
        .y_out       (y_out),
        .z_out       (z_out),
        .saturated   (saturated),
        .last_out    (last_out)
    );

endmodule

### hdl/fce_checker.sv
module fce_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               mode,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [47:0] x_out,
    input logic               last_out
);

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == fce_pkg::MODE_EVAL |=> in_stall)
        else $error("evaluate transfer did not stall the input");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == fce_pkg::MODE_LOAD |=> !in_stall)
        else $error("load transfer left the input stalled");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an evaluation in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_out) && $stable(last_out))
        else $error("stalled result changed");

endmodule

bind fourier_curve_evaluator_unit fce_checker u_fce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_out     (x_out),
    .last_out  (last_out)
);
